// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the scheduler RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define DSCH_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("dsch assertion failed");

// condition must never be true outside reset
`define DSCH_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("dsch forbidden condition seen");

`else

`define DSCH_ASSERT(lbl, clk, rst_n, prop)
`define DSCH_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== sv/dsch_pkg.sv =====
package dsch_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int TRACK_BITS_DEF  = 16;
	localparam int TAG_BITS_DEF    = 8;

	localparam int TRACK_W = 16;
	localparam int TAG_W   = 8;
	localparam int COST_W  = 32;
	localparam int STAMP_W = 32;
	localparam int STEP_W  = 16;

	localparam logic [STEP_W-1:0] STEP_COST_RST = 16'd200;

	localparam logic ACT_ENQ = 1'b0;
	localparam logic ACT_DEQ = 1'b1;

	typedef enum logic [1:0] {
		ST_ENQUEUED = 2'd0,
		ST_FULL     = 2'd1,
		ST_GRANTED  = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef struct packed {
		logic               action;
		logic [TRACK_W-1:0] req_track;
		logic [TAG_W-1:0]   req_tag;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [TAG_W-1:0]   grant_tag;
		logic [TRACK_W-1:0] grant_track;
		logic [COST_W-1:0]  search_cost;
		logic               heading_up;
	} rsp_t;

	typedef struct packed {
		logic clear;
		logic sample;
	} pick_ctl_t;

endpackage

// ===== sv/dsch_ram.sv =====
module dsch_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/dsch_pick.sv =====
`include "assert_macros.svh"

module dsch_pick #(
	parameter int QUEUE_DEPTH = dsch_pkg::QUEUE_DEPTH_DEF,
	parameter int TRACK_BITS  = dsch_pkg::TRACK_BITS_DEF,
	parameter int TAG_BITS    = dsch_pkg::TAG_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dsch_pkg::pick_ctl_t            ctl,
	input  logic [$clog2(QUEUE_DEPTH)-1:0] idx,
	input  logic [TRACK_BITS-1:0]          track,
	input  logic [TAG_BITS-1:0]            tag,
	input  logic [dsch_pkg::STAMP_W-1:0]   stamp,
	input  logic [TRACK_BITS-1:0]          head,
	input  logic                           dir_up,
	input  logic [dsch_pkg::STAMP_W-1:0]   insert_cnt,
	output logic                           found,
	output logic [$clog2(QUEUE_DEPTH)-1:0] best_idx,
	output logic [TRACK_BITS-1:0]          best_track,
	output logic [TAG_BITS-1:0]            best_tag
);

	import dsch_pkg::*;

	localparam int IDX_W = $clog2(QUEUE_DEPTH);

	logic                best_found_q;
	logic [IDX_W-1:0]    best_idx_q;
	logic [TRACK_BITS-1:0] best_track_q;
	logic [TAG_BITS-1:0] best_tag_q;
	logic [STAMP_W-1:0]  best_age_q;

	logic [STAMP_W-1:0]  age;
	logic                ahead;
	logic                closer;
	logic                newer;
	logic                take;

	always_comb begin
		age    = insert_cnt - stamp;
		ahead  = dir_up ? (track >= head) : (track <= head);
		closer = dir_up ? (track < best_track_q) : (track > best_track_q);
		// equal tracks: the smaller age is the newer request
		newer  = (track == best_track_q) && (age < best_age_q);
		take   = ctl.sample && ahead && (!best_found_q || closer || newer);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_found_q <= 1'b0;
		end else if (ctl.clear) begin
			best_found_q <= 1'b0;
		end else if (take) begin
			best_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q   <= idx;
			best_track_q <= track;
			best_tag_q   <= tag;
			best_age_q   <= age;
		end
	end

	assign found      = best_found_q;
	assign best_idx   = best_idx_q;
	assign best_track = best_track_q;
	assign best_tag   = best_tag_q;

	`DSCH_ASSERT(a_clear_drops_best, clk, arst_n, ctl.clear |=> !best_found_q)
	`DSCH_ASSERT(a_best_held, clk, arst_n, (best_found_q && !ctl.clear) |=> best_found_q)
	`DSCH_NEVER(a_clear_sample_overlap, clk, arst_n, ctl.clear && ctl.sample)

endmodule

// ===== sv/disk_elevator_scheduler_core.sv =====
// Enqueue: result in START when the table is full, else in FIND, after
//   a walk over the valid bits, one slot a cycle, to the lowest free slot.
// Dequeue: each search pass walks SCAN, one slot-memory read a cycle, then DRAIN;
//   result in DECIDE, or after a second pass when the direction flips.
// One word in flight; the next word is taken once the result sits in the output register.
// Reset: valid bits, counters and head cleared, scan upward, step_cost 200; slot memory kept.
`include "assert_macros.svh"

module disk_elevator_scheduler_core #(
	parameter int QUEUE_DEPTH = dsch_pkg::QUEUE_DEPTH_DEF,
	parameter int TRACK_BITS  = dsch_pkg::TRACK_BITS_DEF,
	parameter int TAG_BITS    = dsch_pkg::TAG_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  dsch_pkg::req_t              req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output dsch_pkg::rsp_t              rsp,
	input  logic                        cfg_we,
	input  logic [dsch_pkg::STEP_W-1:0] cfg_wdata
);

	import dsch_pkg::*;

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int ENT_W = TRACK_BITS + TAG_BITS + STAMP_W;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_START  = 6'b000010,
		S_FIND   = 6'b000100,
		S_SCAN   = 6'b001000,
		S_DRAIN  = 6'b010000,
		S_DECIDE = 6'b100000
	} state_t;

	state_t                state_q;
	logic                  act_q;
	logic [TRACK_BITS-1:0] trk_q;
	logic [TAG_BITS-1:0]   tag_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  rd_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic                  vld_s1;
	logic [QUEUE_DEPTH-1:0] slot_valid_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [STAMP_W-1:0]    ins_q;
	logic [TRACK_BITS-1:0] head_q;
	logic                  dir_q;
	logic [STEP_W-1:0]     step_q;
	logic [COST_W-1:0]     prod_q;
	logic [COST_W-1:0]     cost_q;
	logic                  second_q;
	rsp_t                  rsp_q;
	logic                  rsp_valid_q;

	logic                  fin;
	logic                  fire;
	rsp_t                  fin_rsp;
	logic                  ram_we;
	logic [ENT_W-1:0]      ram_wdata;
	logic [ENT_W-1:0]      ram_rdata;
	pick_ctl_t             pick_ctl;
	logic                  pick_found;
	logic [IDX_W-1:0]      pick_idx;
	logic [TRACK_BITS-1:0] pick_track;
	logic [TAG_BITS-1:0]   pick_tag;

	// slot entry: {track, tag, stamp}
	assign ram_wdata = {trk_q, tag_q, ins_q};
	assign ram_we    = fire && (state_q == S_FIND);

	dsch_ram #(
		.WIDTH(ENT_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata(ram_wdata),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	always_comb begin
		pick_ctl.sample = rd_s1 && vld_s1;
		pick_ctl.clear  = ((state_q == S_START) && (act_q == ACT_DEQ) && (cnt_q != '0)) ||
			((state_q == S_DECIDE) && !pick_found);
	end

	dsch_pick #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.TRACK_BITS (TRACK_BITS),
		.TAG_BITS   (TAG_BITS)
	) u_pick (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (pick_ctl),
		.idx       (idx_s1),
		.track     (ram_rdata[ENT_W-1 -: TRACK_BITS]),
		.tag       (ram_rdata[STAMP_W +: TAG_BITS]),
		.stamp     (ram_rdata[STAMP_W-1:0]),
		.head      (head_q),
		.dir_up    (dir_q),
		.insert_cnt(ins_q),
		.found     (pick_found),
		.best_idx  (pick_idx),
		.best_track(pick_track),
		.best_tag  (pick_tag)
	);

	// result of the current word, if it finishes this cycle
	always_comb begin
		fin                 = 1'b0;
		fin_rsp.status      = ST_ENQUEUED;
		fin_rsp.grant_tag   = '0;
		fin_rsp.grant_track = '0;
		fin_rsp.search_cost = '0;
		fin_rsp.heading_up  = dir_q;
		case (state_q)
			S_START: begin
				if (act_q == ACT_ENQ && cnt_q == CNT_FULL) begin
					fin            = 1'b1;
					fin_rsp.status = ST_FULL;
				end else if (act_q == ACT_DEQ && cnt_q == '0) begin
					fin            = 1'b1;
					fin_rsp.status = ST_EMPTY;
				end
			end
			S_FIND: begin
				if (!slot_valid_q[idx_q]) begin
					fin            = 1'b1;
					fin_rsp.status = ST_ENQUEUED;
				end
			end
			S_DECIDE: begin
				if (pick_found) begin
					fin                 = 1'b1;
					fin_rsp.status      = ST_GRANTED;
					fin_rsp.grant_tag   = TAG_W'(pick_tag);
					fin_rsp.grant_track = TRACK_W'(pick_track);
					fin_rsp.search_cost = cost_q + prod_q;
				end
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	assign fire = fin && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rd_s1        <= 1'b0;
			slot_valid_q <= '0;
			cnt_q        <= '0;
			ins_q        <= '0;
			head_q       <= '0;
			dir_q        <= 1'b1;
			step_q       <= STEP_COST_RST;
			second_q     <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				step_q <= cfg_wdata;
			end
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			rd_s1 <= (state_q == S_SCAN);
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					if (fire) begin
						state_q <= S_IDLE;
					end else if (!fin) begin
						second_q <= 1'b0;
						state_q  <= (act_q == ACT_ENQ) ? S_FIND : S_SCAN;
					end
				end
				S_FIND: begin
					if (fire) begin
						slot_valid_q[idx_q] <= 1'b1;
						cnt_q               <= cnt_q + 1'b1;
						ins_q               <= ins_q + 1'b1;
						state_q             <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (idx_q == IDX_LAST) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (fire) begin
						slot_valid_q[pick_idx] <= 1'b0;
						cnt_q                  <= cnt_q - 1'b1;
						head_q                 <= pick_track;
						state_q                <= S_IDLE;
					end else if (!pick_found) begin
						// nothing ahead: turn round and search again
						dir_q    <= ~dir_q;
						second_q <= 1'b1;
						state_q  <= S_SCAN;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			act_q <= req.action;
			trk_q <= TRACK_BITS'(req.req_track);
			tag_q <= TAG_BITS'(req.req_tag);
		end
		if (fire) begin
			rsp_q <= fin_rsp;
		end
		idx_s1 <= idx_q;
		vld_s1 <= slot_valid_q[idx_q];
		case (state_q)
			S_START: begin
				idx_q  <= '0;
				cost_q <= '0;
				prod_q <= COST_W'(cnt_q) * COST_W'(step_q);
			end
			S_FIND: begin
				if (slot_valid_q[idx_q]) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			S_SCAN: begin
				if (idx_q != IDX_LAST) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			S_DECIDE: begin
				if (!pick_found) begin
					idx_q  <= '0;
					cost_q <= prod_q;
				end
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`DSCH_ASSERT(a_count_bound, clk, arst_n, cnt_q <= CNT_FULL)
	`DSCH_NEVER(a_second_pass_finds, clk, arst_n, (state_q == S_DECIDE) && second_q && !pick_found)
	`DSCH_ASSERT(a_count_matches, clk, arst_n, $countones(slot_valid_q) == int'(cnt_q))

endmodule

// ===== bench/tb_disk_elevator_scheduler_core.sv =====
`timescale 1ns / 100ps

module tb_disk_elevator_scheduler_core;
	import dsch_pkg::*;

	localparam int SLOTS       = 16;
	localparam int STUCK_LIMIT = 2000;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_ready;
	req_t               req       = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	rsp_t               rsp;
	logic               cfg_we    = 1'b0;
	logic [STEP_W-1:0]  cfg_wdata = '0;

	// scheduler state as the testbench believes it to be
	logic [STEP_W-1:0]  cost_per_slot;
	bit                 slot_used [SLOTS];
	logic [TRACK_W-1:0] slot_trk  [SLOTS];
	logic [TAG_W-1:0]   slot_id   [SLOTS];
	logic [STAMP_W-1:0] slot_seq  [SLOTS];
	logic [STAMP_W-1:0] seq_count;
	logic [TRACK_W-1:0] head_pos;
	bit                 sweep_up;

	rsp_t sched_rsp_q [$];
	rsp_t want;
	int   bad_words   = 0;
	int   stuck_cycles = 0;
	int   rx_hold     = 0;
	bit   tx_idle_on  = 1'b0;
	bit   rx_idle_on  = 1'b0;

	disk_elevator_scheduler_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic int idle_gap(bit on);
		int r;
		r = $urandom_range(0, 99);
		if (!on || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// one SCAN pass from the head in the current direction; -1 if nothing lies ahead
	function automatic int nearest_ahead();
		int best;
		best = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_used[i] && (sweep_up ? slot_trk[i] >= head_pos : slot_trk[i] <= head_pos)) begin
				if (best < 0)
					best = i;
				else if (sweep_up ? slot_trk[i] < slot_trk[best] : slot_trk[i] > slot_trk[best])
					best = i;
				else if (slot_trk[i] == slot_trk[best] &&
						(seq_count - slot_seq[i]) < (seq_count - slot_seq[best]))
					best = i;
			end
		end
		return best;
	endfunction

	function automatic rsp_t schedule_word(req_t w);
		rsp_t        r;
		int          slot;
		int          busy;
		logic [31:0] pass_cost;
		r = '0;
		if (w.action == ACT_ENQ) begin
			slot = -1;
			for (int i = SLOTS - 1; i >= 0; i--)
				if (!slot_used[i])
					slot = i;
			if (slot < 0) begin
				r.status = ST_FULL;
			end else begin
				slot_used[slot] = 1'b1;
				slot_trk[slot]  = w.req_track;
				slot_id[slot]   = w.req_tag;
				slot_seq[slot]  = seq_count;
				seq_count       = seq_count + 1;
				r.status        = ST_ENQUEUED;
			end
		end else begin
			busy = 0;
			for (int i = 0; i < SLOTS; i++)
				busy += slot_used[i];
			if (busy == 0) begin
				r.status = ST_EMPTY;
			end else begin
				pass_cost     = busy * 32'(cost_per_slot);
				r.search_cost = pass_cost;
				slot          = nearest_ahead();
				if (slot < 0) begin
					// nothing ahead: turn round and charge a second pass
					sweep_up      = !sweep_up;
					slot          = nearest_ahead();
					r.search_cost = r.search_cost + pass_cost;
				end
				r.status        = ST_GRANTED;
				r.grant_tag     = slot_id[slot];
				r.grant_track   = slot_trk[slot];
				head_pos        = slot_trk[slot];
				slot_used[slot] = 1'b0;
			end
		end
		r.heading_up = sweep_up;
		return r;
	endfunction

	function automatic void flag_error(string what);
		bad_words++;
		if (bad_words <= 10)
			$display("%t %s", $realtime, what);
	endfunction

	// receiver stalls
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			rx_hold   <= rx_hold - 1;
			rsp_ready <= 1'b0;
		end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
			rx_hold   <= idle_gap(1'b1);
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (sched_rsp_q.size() == 0) begin
				flag_error($sformatf("unexpected word: st=%0d tag=%02h trk=%04h cost=%0d up=%0b",
					rsp.status, rsp.grant_tag, rsp.grant_track, rsp.search_cost, rsp.heading_up));
			end else begin
				want = sched_rsp_q.pop_front();
				if (rsp.status !== want.status || rsp.grant_tag !== want.grant_tag ||
						rsp.grant_track !== want.grant_track ||
						rsp.search_cost !== want.search_cost ||
						rsp.heading_up !== want.heading_up)
					flag_error($sformatf({"mismatch: exp st=%0d tag=%02h trk=%04h cost=%0d up=%0b",
						" got st=%0d tag=%02h trk=%04h cost=%0d up=%0b"},
						want.status, want.grant_tag, want.grant_track, want.search_cost,
						want.heading_up, rsp.status, rsp.grant_tag, rsp.grant_track,
						rsp.search_cost, rsp.heading_up));
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles == STUCK_LIMIT) begin
			$display("tb_disk_elevator_scheduler_core: done, errors");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	task automatic send_word(req_t w);
		int gap;
		gap = idle_gap(tx_idle_on);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= w;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		sched_rsp_q.push_back(schedule_word(w));
	endtask

	task automatic enqueue(logic [TRACK_W-1:0] trk, logic [TAG_W-1:0] tag);
		req_t w;
		w.action    = ACT_ENQ;
		w.req_track = trk;
		w.req_tag   = tag;
		send_word(w);
	endtask

	task automatic dequeue();
		req_t w;
		w.action    = ACT_DEQ;
		w.req_track = 16'($urandom_range(0, 65535));
		w.req_tag   = 8'($urandom_range(0, 255));
		send_word(w);
	endtask

	task automatic wait_all_results();
		req_valid <= 1'b0;
		while (sched_rsp_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_step_cost(logic [STEP_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cost_per_slot = v;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_empty_queue();
		dequeue();
		dequeue();
	endtask

	task automatic test_scan_order();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		enqueue(16'h8000, 8'h01);
		enqueue(16'h8000, 8'h02);
		enqueue(16'h0000, 8'h00);
		enqueue(16'hFFFF, 8'hFF);
		enqueue(16'h4000, 8'h05);
		dequeue();               // head 0, upward: track 0 itself counts as ahead
		dequeue();
		dequeue();               // equal tracks: newer tag 02 first
		enqueue(16'h1000, 8'h07);
		dequeue();
		dequeue();
		dequeue();               // only 1000 left behind the head: turn round
		dequeue();               // empty, direction stays down
	endtask

	task automatic test_full_table();
		for (int i = 0; i < SLOTS; i++)
			enqueue(16'(i % 3) * 16'h7FFF, 8'(i * 17));
		enqueue(16'hFFFF, 8'hFF); // dropped
		dequeue();
	endtask

	function automatic logic [TRACK_W-1:0] pick_track();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return 16'($urandom_range(0, 65535));
		if (r < 8)
			return 16'($urandom_range(0, 3)) * 16'h5555;
		return head_pos + 16'($urandom_range(0, 4)) - 16'd2;
	endfunction

	task automatic test_random_mix(int n, logic [STEP_W-1:0] cost, int enq_pct, bit tx, bit rx);
		wait_all_results();
		write_step_cost(cost);
		tx_idle_on = tx;
		rx_idle_on = rx;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < enq_pct)
				enqueue(pick_track(), 8'($urandom_range(0, 255)));
			else
				dequeue();
		end
	endtask

	// sender holds off mid-stream until every result is back
	task automatic test_drain_pause();
		test_random_mix(40, 16'($urandom_range(0, 65535)), 60, 1'b1, 1'b1);
		wait_all_results();
		for (int i = 0; i < 40; i++) begin
			if ($urandom_range(0, 1))
				enqueue(pick_track(), 8'($urandom_range(0, 255)));
			else
				dequeue();
		end
	endtask

	initial begin
		cost_per_slot = STEP_COST_RST;
		seq_count     = '0;
		head_pos      = '0;
		sweep_up      = 1'b1;
		for (int i = 0; i < SLOTS; i++)
			slot_used[i] = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_queue();
		test_scan_order();
		test_full_table();
		test_random_mix(240, 16'd0, 55, 1'b1, 1'b1);
		test_random_mix(240, 16'hFFFF, 75, 1'b1, 1'b0);
		test_random_mix(240, 16'd1, 35, 1'b0, 1'b1);
		test_drain_pause();
		test_random_mix(240, 16'($urandom_range(0, 65535)), 50, 1'b0, 1'b0);
		test_random_mix(300, STEP_COST_RST, 60, 1'b1, 1'b1);

		wait_all_results();
		repeat (40) @(posedge clk);
		if (bad_words == 0 && sched_rsp_q.size() == 0)
			$display("tb_disk_elevator_scheduler_core: done, clean");
		else
			$display("tb_disk_elevator_scheduler_core: done, errors");
		$finish;
	end

endmodule
